[hw/rtl/swsa_pkg.sv]
// ----------------------------------------------------------------------------
// swsa_pkg
// Shared constants, types and tables of the sliding-window sink attention unit.
// ----------------------------------------------------------------------------
package swsa_pkg;

   localparam int MAX_SEQ  = 1024;
   localparam int HEAD_DIM = 64;

   localparam int DATA_W   = 16;
   localparam int CFG_W    = 11;
   localparam int POS_W    = $clog2(MAX_SEQ + 1);
   localparam int IDX_W    = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;
   localparam int KV_DEPTH = MAX_SEQ * HEAD_DIM;
   localparam int KV_AW    = (KV_DEPTH > 1) ? $clog2(KV_DEPTH) : 1;
   localparam int SEQ_AW   = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
   localparam int CMP_W    = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;

   // arithmetic widths
   localparam int DOT_W    = 32 + IDX_W;
   localparam int SCL_W    = 18;
   localparam int SCALED_W = DOT_W + SCL_W;
   localparam int SC_W     = SCALED_W - 22;
   localparam int U_W      = SC_W + 1;
   localparam int W_W      = 17;
   localparam int SUM_W    = W_W + POS_W;
   localparam int ACC_W    = W_W + DATA_W + POS_W;
   localparam int NUM_W    = ACC_W + 1;
   localparam int CNT_W    = $clog2(NUM_W + 1);

   localparam logic [14:0] LOG2E_Q14 = 15'd23637;

   // CSR map
   localparam int CSR_AW     = 3;
   localparam int REG_SINK   = 0;
   localparam int REG_WINDOW = 1;
   localparam logic [CFG_W-1:0] WINDOW_RESET = 11'd1024;

   // rounded integer square root, evaluated at elaboration
   function automatic longint unsigned isqrt_round(input longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      longint unsigned v;
      r = 0;
      b = 64'd1 << 62;
      v = x;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (x - r * r > r) r = r + 1;
      return r;
   endfunction

   localparam longint unsigned SCALE_VAL = isqrt_round((64'd1 << 32) / HEAD_DIM);
   localparam logic signed [SCL_W-1:0] SCALE_Q16 = SCL_W'(SCALE_VAL);

   // 2^(-k/16), Q1.16
   function automatic logic [16:0] pow_hi(input logic [3:0] k);
      case (k)
         4'd0:    pow_hi = 17'd65536;
         4'd1:    pow_hi = 17'd62757;
         4'd2:    pow_hi = 17'd60097;
         4'd3:    pow_hi = 17'd57549;
         4'd4:    pow_hi = 17'd55109;
         4'd5:    pow_hi = 17'd52773;
         4'd6:    pow_hi = 17'd50535;
         4'd7:    pow_hi = 17'd48393;
         4'd8:    pow_hi = 17'd46341;
         4'd9:    pow_hi = 17'd44376;
         4'd10:   pow_hi = 17'd42495;
         4'd11:   pow_hi = 17'd40693;
         4'd12:   pow_hi = 17'd38968;
         4'd13:   pow_hi = 17'd37316;
         4'd14:   pow_hi = 17'd35734;
         default: pow_hi = 17'd34219;
      endcase
   endfunction

   // 2^(-k/256), Q1.16
   function automatic logic [16:0] pow_lo(input logic [3:0] k);
      case (k)
         4'd0:    pow_lo = 17'd65536;
         4'd1:    pow_lo = 17'd65359;
         4'd2:    pow_lo = 17'd65182;
         4'd3:    pow_lo = 17'd65006;
         4'd4:    pow_lo = 17'd64830;
         4'd5:    pow_lo = 17'd64655;
         4'd6:    pow_lo = 17'd64480;
         4'd7:    pow_lo = 17'd64306;
         4'd8:    pow_lo = 17'd64132;
         4'd9:    pow_lo = 17'd63958;
         4'd10:   pow_lo = 17'd63785;
         4'd11:   pow_lo = 17'd63613;
         4'd12:   pow_lo = 17'd63441;
         4'd13:   pow_lo = 17'd63269;
         4'd14:   pow_lo = 17'd63098;
         default: pow_lo = 17'd62928;
      endcase
   endfunction

   // one finished token handed from front to back
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             ovf;
      logic             win;
      logic [CFG_W-1:0] sink;
      logic [CFG_W-1:0] window;
   } job_type;

   // cache and query buffer write from the front
   typedef struct packed {
      logic              q_we;
      logic              kv_we;
      logic [IDX_W-1:0]  idx;
      logic [KV_AW-1:0]  kv_addr;
      logic [DATA_W-1:0] q;
      logic [DATA_W-1:0] k;
      logic [DATA_W-1:0] v;
   } wr_type;

endpackage

[hw/rtl/swsa_front.sv]
// ----------------------------------------------------------------------------
// swsa_front
// Takes element requests, tracks token position and element index, writes
// the caches and hands each finished token to the job queue.
// ----------------------------------------------------------------------------
module swsa_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_start_of_sequence,
   input  logic                      req_windowed,
   input  logic [swsa_pkg::DATA_W-1:0] req_q_elem,
   input  logic [swsa_pkg::DATA_W-1:0] req_k_elem,
   input  logic [swsa_pkg::DATA_W-1:0] req_v_elem,
   input  logic                      req_last_elem,
   input  logic [swsa_pkg::CFG_W-1:0] sink_count,
   input  logic [swsa_pkg::CFG_W-1:0] window_size,
   input  logic                      hold,
   output swsa_pkg::wr_type          wr,
   output logic                      push,
   output swsa_pkg::job_type         job
);
   import swsa_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             win_ff, win_in;

   logic             take;
   logic [POS_W-1:0] cur_pos;
   logic [IDX_W-1:0] cur_idx;
   logic             cur_win;
   logic             tok_end;
   logic             in_range;

   assign req_stall = hold;
   assign take      = req_valid && !hold;

   // restart applies before the request is taken
   always_comb begin
      cur_pos  = req_start_of_sequence ? '0 : pos_ff;
      cur_idx  = req_start_of_sequence ? '0 : idx_ff;
      cur_win  = req_start_of_sequence ? req_windowed : win_ff;
      in_range = (32'(cur_pos) < MAX_SEQ);
      tok_end  = req_last_elem || (32'(cur_idx) == HEAD_DIM - 1);
   end

   // cache writes
   always_comb begin
      wr.q_we    = take;
      wr.kv_we   = take && in_range;
      wr.idx     = cur_idx;
      wr.kv_addr = KV_AW'(32'(cur_pos) * HEAD_DIM + 32'(cur_idx));
      wr.q       = req_q_elem;
      wr.k       = req_k_elem;
      wr.v       = req_v_elem;
   end

   // job for the back end
   always_comb begin
      push       = take && tok_end;
      job.pos    = cur_pos;
      job.ovf    = !in_range;
      job.win    = cur_win;
      job.sink   = sink_count;
      job.window = window_size;
   end

   // counters
   always_comb begin
      pos_in = pos_ff;
      idx_in = idx_ff;
      win_in = win_ff;
      if (take) begin
         win_in = cur_win;
         if (tok_end) begin
            idx_in = '0;
            pos_in = in_range ? cur_pos + 1'b1 : cur_pos;
         end else begin
            idx_in = cur_idx + 1'b1;
            pos_in = cur_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         idx_ff <= '0;
         win_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         idx_ff <= idx_in;
         win_ff <= win_in;
      end
   end

endmodule

[hw/rtl/swsa_queue.sv]
// ----------------------------------------------------------------------------
// swsa_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
module swsa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  swsa_pkg::job_type push_job,
   input  logic              pop,
   output logic              empty,
   output swsa_pkg::job_type head
);
   import swsa_pkg::*;

   job_type    slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push;
   logic       do_pop;

   assign empty   = (cnt_ff == 2'd0);
   assign head    = slot_ff[rp_ff];
   assign do_pop  = pop && !empty;
   assign do_push = push && (cnt_ff != 2'd2);

   always_comb begin
      wp_in  = do_push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wp_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[hw/rtl/swsa_back.sv]
// ----------------------------------------------------------------------------
// swsa_back
// Holds the caches and runs one token: score pass, softmax weight and
// value accumulation pass, then a serial divide per output element.
// ----------------------------------------------------------------------------
module swsa_back (
   input  logic                        clock,
   input  logic                        reset,
   input  swsa_pkg::wr_type            wr,
   input  logic                        job_empty,
   input  swsa_pkg::job_type           job_head,
   output logic                        job_pop,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [swsa_pkg::DATA_W-1:0] rsp_out_elem,
   output logic                        rsp_last_out,
   output logic                        rsp_overflow
);
   import swsa_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_START  = 4'd1;
   localparam logic [3:0] ST_P1     = 4'd2;
   localparam logic [3:0] ST_P1_DR  = 4'd3;
   localparam logic [3:0] ST_P2_RD  = 4'd4;
   localparam logic [3:0] ST_P2_U   = 4'd5;
   localparam logic [3:0] ST_P2_W   = 4'd6;
   localparam logic [3:0] ST_P2_W2  = 4'd7;
   localparam logic [3:0] ST_P2_ACC = 4'd8;
   localparam logic [3:0] ST_P2_DR  = 4'd9;
   localparam logic [3:0] ST_P3_RD  = 4'd10;
   localparam logic [3:0] ST_P3_LD  = 4'd11;
   localparam logic [3:0] ST_P3_DIV = 4'd12;
   localparam logic [3:0] ST_P3_OUT = 4'd13;

   // storage
   logic [DATA_W-1:0] key_mem   [KV_DEPTH];
   logic [DATA_W-1:0] val_mem   [KV_DEPTH];
   logic [DATA_W-1:0] q_mem     [HEAD_DIM];
   logic [SC_W-1:0]   score_mem [MAX_SEQ];
   logic [ACC_W-1:0]  acc_mem   [HEAD_DIM];

   logic [DATA_W-1:0] key_rd_ff, val_rd_ff, q_rd_ff;
   logic [SC_W-1:0]   score_rd_ff;
   logic [ACC_W-1:0]  acc_rd_ff;
   logic [KV_AW-1:0]  kv_ra;

   // control
   logic [3:0]       state_ff, state_in;
   job_type          job_ff, job_in;
   logic [CMP_W-1:0] lo_ff, lo_in;
   logic [POS_W-1:0] s_ff, s_in;
   logic [IDX_W-1:0] d_ff, d_in;
   logic             sel_now;
   logic             d_last;
   logic             s_last;

   // score pass pipeline
   logic                     a_v_ff, a_first_ff, a_last_ff;
   logic [POS_W-1:0]         a_s_ff;
   logic                     b_v_ff, b_first_ff, b_last_ff;
   logic [POS_W-1:0]         b_s_ff;
   logic signed [31:0]       prod_ff;
   logic signed [DOT_W-1:0]  dot_ff;
   logic                     c_v_ff;
   logic [POS_W-1:0]         c_s_ff;
   logic signed [SCALED_W-1:0] scaled_ff;
   logic                     e_v_ff;
   logic [POS_W-1:0]         e_s_ff;
   logic signed [SC_W-1:0]   sc_new;
   logic signed [SC_W-1:0]   max_ff;
   logic                     have_ff;
   logic                     p1_issue;

   // weight and accumulate
   logic [U_W-1:0]    u_ff;
   logic [33:0]       pr_ff;
   logic [4:0]        ip_ff;
   logic              big_ff;
   logic [W_W-1:0]    w_ff;
   logic [W_W-1:0]    w_new;
   logic [SUM_W-1:0]  sum_ff;
   logic              first_pos_ff;
   logic              x_v_ff, x_first_ff;
   logic [IDX_W-1:0]  x_d_ff;
   logic              y_v_ff, y_first_ff;
   logic [IDX_W-1:0]  y_d_ff;
   logic signed [33:0] prod2_ff;
   logic [ACC_W-1:0]  accy_ff;
   logic              p2_issue;
   logic [SC_W-1:0]   diff_u;

   // divide
   logic [NUM_W-1:0]  n_ff;
   logic [SUM_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              neg_ff;
   logic              zero_out;
   logic [SUM_W:0]    trial;
   logic              qbit;
   logic [ACC_W-1:0]  mag;
   logic [DATA_W-1:0] out_val;
   logic              out_free;

   assign busy     = (state_ff != ST_IDLE);
   assign job_pop  = (state_ff == ST_IDLE) && !job_empty;
   assign d_last   = (32'(d_ff) == HEAD_DIM - 1);
   assign s_last   = (s_ff == job_ff.pos);
   assign sel_now  = !job_ff.win || (CMP_W'(s_ff) < CMP_W'(job_ff.sink)) ||
                     (CMP_W'(s_ff) >= lo_ff);
   assign kv_ra    = KV_AW'(32'(s_ff) * HEAD_DIM + 32'(d_ff));
   assign p1_issue = (state_ff == ST_P1) && sel_now;
   assign p2_issue = (state_ff == ST_P2_ACC);
   assign zero_out = job_ff.ovf || (sum_ff == '0);
   assign out_free = !rsp_valid || !rsp_stall;

   // memories
   always_ff @(posedge clock) begin
      if (wr.kv_we) begin
         key_mem[wr.kv_addr] <= wr.k;
         val_mem[wr.kv_addr] <= wr.v;
      end
      key_rd_ff <= key_mem[kv_ra];
      val_rd_ff <= val_mem[kv_ra];
   end

   always_ff @(posedge clock) begin
      if (wr.q_we) q_mem[wr.idx] <= wr.q;
      q_rd_ff <= q_mem[d_ff];
   end

   always_ff @(posedge clock) begin
      if (e_v_ff) score_mem[e_s_ff[SEQ_AW-1:0]] <= sc_new;
      score_rd_ff <= score_mem[s_ff[SEQ_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (y_v_ff) begin
         acc_mem[y_d_ff] <= y_first_ff ? ACC_W'(prod2_ff)
                                       : accy_ff + ACC_W'(prod2_ff);
      end
      acc_rd_ff <= acc_mem[d_ff];
   end

   // score pass datapath: read, multiply, accumulate, scale, store
   assign sc_new = scaled_ff[SCALED_W-1:22];

   always_ff @(posedge clock) begin
      a_first_ff <= (d_ff == '0);
      a_last_ff  <= d_last;
      a_s_ff     <= s_ff;
      b_first_ff <= a_first_ff;
      b_last_ff  <= a_last_ff;
      b_s_ff     <= a_s_ff;
      prod_ff    <= $signed(q_rd_ff) * $signed(key_rd_ff);
      if (b_v_ff) dot_ff <= b_first_ff ? DOT_W'(prod_ff) : dot_ff + DOT_W'(prod_ff);
      c_s_ff     <= b_s_ff;
      scaled_ff  <= SCALED_W'(dot_ff) * SCALED_W'(SCALE_Q16);
      e_s_ff     <= c_s_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
      end else begin
         a_v_ff <= p1_issue;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff && b_last_ff;
         e_v_ff <= c_v_ff;
      end
   end

   // weight: exponent split into integer shift and two table factors
   assign diff_u = SC_W'(max_ff - $signed(score_rd_ff));
   always_comb begin
      logic [17:0] rounded;
      rounded = 18'((pr_ff + 34'd32768) >> 16);
      w_new   = big_ff ? '0 : W_W'(rounded >> ip_ff);
   end

   // accumulate pipeline
   always_ff @(posedge clock) begin
      x_first_ff <= first_pos_ff;
      x_d_ff     <= d_ff;
      y_first_ff <= x_first_ff;
      y_d_ff     <= x_d_ff;
      prod2_ff   <= $signed({1'b0, w_ff}) * $signed(val_rd_ff);
      accy_ff    <= acc_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_v_ff <= 1'b0;
         y_v_ff <= 1'b0;
      end else begin
         x_v_ff <= p2_issue;
         y_v_ff <= x_v_ff;
      end
   end

   // divider step
   always_comb begin
      trial = {rem_ff, n_ff[NUM_W-1]};
      qbit  = (trial >= {1'b0, sum_ff});
      mag   = acc_rd_ff[ACC_W-1] ? -acc_rd_ff : acc_rd_ff;
   end

   // saturate the rounded quotient
   always_comb begin
      out_val = '0;
      if (!zero_out) begin
         if (neg_ff) begin
            out_val = (n_ff > NUM_W'(32768)) ? DATA_W'(-32768) : DATA_W'(-n_ff);
         end else begin
            out_val = (n_ff > NUM_W'(32767)) ? DATA_W'(32767) : DATA_W'(n_ff);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      lo_in    = lo_ff;
      s_in     = s_ff;
      d_in     = d_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_in   = job_head;
               state_in = ST_START;
            end
         end
         ST_START: begin
            s_in = '0;
            d_in = '0;
            if (CMP_W'(job_ff.pos) + 1'b1 > CMP_W'(job_ff.window)) begin
               lo_in = CMP_W'(job_ff.pos) + 1'b1 - CMP_W'(job_ff.window);
            end else begin
               lo_in = '0;
            end
            state_in = job_ff.ovf ? ST_P3_RD : ST_P1;
         end
         ST_P1: begin
            if (!sel_now || d_last) begin
               d_in = '0;
               if (s_last) state_in = ST_P1_DR;
               else s_in = s_ff + 1'b1;
            end else begin
               d_in = d_ff + 1'b1;
            end
         end
         ST_P1_DR: begin
            if (!a_v_ff && !b_v_ff && !c_v_ff && !e_v_ff) begin
               s_in     = '0;
               d_in     = '0;
               state_in = have_ff ? ST_P2_RD : ST_P3_RD;
            end
         end
         ST_P2_RD: begin
            if (sel_now) begin
               state_in = ST_P2_U;
            end else if (s_last) begin
               state_in = ST_P2_DR;
            end else begin
               s_in = s_ff + 1'b1;
            end
         end
         ST_P2_U:  state_in = ST_P2_W;
         ST_P2_W:  state_in = ST_P2_W2;
         ST_P2_W2: begin
            d_in     = '0;
            state_in = ST_P2_ACC;
         end
         ST_P2_ACC: begin
            if (d_last) begin
               d_in = '0;
               if (s_last) begin
                  state_in = ST_P2_DR;
               end else begin
                  s_in     = s_ff + 1'b1;
                  state_in = ST_P2_RD;
               end
            end else begin
               d_in = d_ff + 1'b1;
            end
         end
         ST_P2_DR: begin
            if (!x_v_ff && !y_v_ff) begin
               d_in     = '0;
               state_in = ST_P3_RD;
            end
         end
         ST_P3_RD: state_in = ST_P3_LD;
         ST_P3_LD: state_in = zero_out ? ST_P3_OUT : ST_P3_DIV;
         ST_P3_DIV: begin
            if (32'(cnt_ff) == NUM_W - 1) state_in = ST_P3_OUT;
         end
         ST_P3_OUT: begin
            if (out_free) begin
               if (d_last) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in     = d_ff + 1'b1;
                  state_in = ST_P3_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff <= job_in;
      lo_ff  <= lo_in;
      s_ff   <= s_in;
      d_ff   <= d_in;
   end

   // running max, weights, sums and divider registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_START) begin
         have_ff      <= 1'b0;
         sum_ff       <= '0;
         first_pos_ff <= 1'b1;
      end
      if (e_v_ff && (!have_ff || sc_new > max_ff)) begin
         max_ff  <= sc_new;
         have_ff <= 1'b1;
      end
      if (state_ff == ST_P2_U) begin
         u_ff <= U_W'((U_W + 14)'(diff_u) * (U_W + 14)'(LOG2E_Q14) >> 14);
      end
      if (state_ff == ST_P2_W) begin
         pr_ff  <= 34'(pow_hi(u_ff[15:12])) * 34'(pow_lo(u_ff[11:8]));
         big_ff <= (u_ff[U_W-1:16] > (U_W - 16)'(16));
         ip_ff  <= u_ff[20:16];
      end
      if (state_ff == ST_P2_W2) begin
         w_ff   <= w_new;
         sum_ff <= sum_ff + SUM_W'(w_new);
      end
      if ((state_ff == ST_P2_ACC) && d_last) first_pos_ff <= 1'b0;
      if (state_ff == ST_P3_LD) begin
         neg_ff <= acc_rd_ff[ACC_W-1];
         n_ff   <= NUM_W'(mag) + NUM_W'(sum_ff >> 1);
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (state_ff == ST_P3_DIV) begin
         n_ff   <= {n_ff[NUM_W-2:0], qbit};
         rem_ff <= qbit ? SUM_W'(trial - {1'b0, sum_ff}) : SUM_W'(trial);
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if ((state_ff == ST_P3_OUT) && out_free) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
      if ((state_ff == ST_P3_OUT) && out_free) begin
         rsp_out_elem <= out_val;
         rsp_last_out <= d_last;
         rsp_overflow <= job_ff.ovf;
      end
   end

endmodule

[hw/rtl/sliding_window_sink_attention_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_sink_attention_unit
// Causal attention for one head with sink plus sliding-window selection.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one query/key/value element per request (Q4.11), with
//  start_of_sequence restarting the head and last_elem closing a token.
//  Keys and values of positions below MAX_SEQ go into the cache.
//  At token end the front queues a job and stalls further requests until
//  the back end has delivered that token's HEAD_DIM results on rsp_*.
//  Element requests are taken one per cycle while req_stall is low. The
//  score and accumulation passes make one cache read and one multiply a
//  cycle for each selected position, the sequencer steps over each
//  skipped position in each pass, and a one-bit-per-cycle divider forms
//  each output element. A token at or beyond MAX_SEQ gives zeros with
//  overflow set.
//  The APB port sets sink_count (0x0) and window_size (0x4); the user must
//  write them only while idle, as the block itself does not enforce it.
//  Reset clears position, element index, queue and sequencer; the caches
//  are not cleared. rsp_stall holds the result register and the back end.
// ----------------------------------------------------------------------------
module sliding_window_sink_attention_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_start_of_sequence,
   input  logic                        req_windowed,
   input  logic signed [15:0]          req_q_elem,
   input  logic signed [15:0]          req_k_elem,
   input  logic signed [15:0]          req_v_elem,
   input  logic                        req_last_elem,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_out_elem,
   output logic                        rsp_last_out,
   output logic                        rsp_overflow,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [swsa_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import swsa_pkg::*;

   logic [CFG_W-1:0] sink_ff, sink_in;
   logic [CFG_W-1:0] window_ff, window_in;
   logic             csr_wr;

   wr_type  wr;
   logic    push;
   job_type push_job;
   job_type head;
   logic    empty;
   logic    pop;
   logic    busy;
   logic    hold;
   logic [DATA_W-1:0] out_elem;

   // register file
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      sink_in   = sink_ff;
      window_in = window_ff;
      if (csr_wr) begin
         if (paddr[CSR_AW-1:2] == 1'(REG_SINK)) sink_in = pwdata[CFG_W-1:0];
         else window_in = pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sink_ff   <= '0;
         window_ff <= WINDOW_RESET;
      end else begin
         sink_ff   <= sink_in;
         window_ff <= window_in;
      end
   end

   assign prdata = (paddr[CSR_AW-1:2] == 1'(REG_WINDOW)) ? 32'(window_ff) : 32'(sink_ff);

   // hold requests while a token is queued or running
   assign hold = !empty || busy;

   swsa_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_start_of_sequence (req_start_of_sequence),
      .req_windowed          (req_windowed),
      .req_q_elem            (req_q_elem),
      .req_k_elem            (req_k_elem),
      .req_v_elem            (req_v_elem),
      .req_last_elem         (req_last_elem),
      .sink_count            (sink_ff),
      .window_size           (window_ff),
      .hold                  (hold),
      .wr                    (wr),
      .push                  (push),
      .job                   (push_job)
   );

   swsa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   swsa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .wr           (wr),
      .job_empty    (empty),
      .job_head     (head),
      .job_pop      (pop),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_elem (out_elem),
      .rsp_last_out (rsp_last_out),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_out_elem = $signed(out_elem);

endmodule
